FILE: design/rgbled_pkg.sv
// ----------------------------------------------------------------------------
// rgbled_pkg
// Shared types and constants for the RGB status LED effect generator.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbled_pkg;

   // effect modes
   typedef enum logic [1:0] {
      MODE_FIXED   = 2'd0,
      MODE_BLINK   = 2'd1,
      MODE_BREATHE = 2'd2,
      MODE_WHEEL   = 2'd3
   } mode_type;

   // control register indexes
   typedef enum logic [2:0] {
      CSR_SHOW_ENABLE     = 3'd0,
      CSR_MODE            = 3'd1,
      CSR_COLOR_RGB       = 3'd2,
      CSR_BRIGHTNESS      = 3'd3,
      CSR_UPDATE_INTERVAL = 3'd4,
      CSR_BLINK_PERIOD    = 3'd5,
      CSR_BLINK_ON_TIME   = 3'd6,
      CSR_STEP_SIZE       = 3'd7
   } csr_index_type;

   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned TIME_W     = 32;
   localparam int unsigned LEVEL_W    = 8;
   localparam int unsigned COMP_W     = 11;   // working color component, two's complement

   // wheel segment bounds
   localparam logic [7:0] WHEEL_SEG1 = 8'h55;
   localparam logic [7:0] WHEEL_SEG2 = 8'hAA;
   localparam logic [7:0] FULL_LEVEL = 8'hFF;

   // floor(x / 510) == (x * DIV510_MULT) >> DIV510_SHIFT for x < 132626
   localparam logic [17:0] DIV510_MULT  = 18'd131587;
   localparam int unsigned DIV510_SHIFT = 26;

   // result buffer
   localparam int unsigned FIFO_DEPTH = 8;
   localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);

endpackage : rgbled_pkg

`default_nettype wire

FILE: design/rgb_status_led_effects.sv
// ----------------------------------------------------------------------------
// rgb_status_led_effects
// Timestamp-driven RGB status LED effects: fixed, blink, breathe, color wheel.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one time stamp per word (free-running 32-bit time base).
//    Each word may produce zero or one rsp_* word of RGB duty levels.
//  - csr_* is a write-only register port (index 0..7); write only while the
//    block is idle. Any write reloads the working color and forces one output.
//  - Pipeline: input register -> effect state update and clip -> brightness
//    product -> reciprocal divide by 510 into an 8-word result FIFO.
//  - A result is offered on rsp_* once it is written to the FIFO after the
//    stage 0, lvl_s1 and prod_s2 registers. Throughput: one word per cycle
//    while req_tready is high, set by the state update loop.
//  - Backpressure: req_tready is driven from a credit counter of registered
//    state only. Each accepted word reserves one FIFO slot; words that give
//    no result return their slot from stage 0. When rsp_tready is low the
//    FIFO absorbs up to 8 words, then req_tready drops.
//  - Reset (synchronous, active high): registers to show on, fixed mode,
//    black, full brightness, interval 0, step 1; effect state cleared; one
//    output pending; FIFO empty.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_status_led_effects
   import rgbled_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   // time stamp input
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [TIME_W-1:0]     req_tdata,    // [31:0] now_time

   // duty level output
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [3*LEVEL_W-1:0]       rsp_tdata,    // [7:0] red, [15:8] green, [23:16] blue

   // register writes
   input  wire logic                  csr_wr_en,
   input  wire logic [2:0]            csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // ------------------------------------------------------------------
   // control registers
   // ------------------------------------------------------------------
   logic                show_en_ff;
   mode_type            mode_ff;
   logic [23:0]         color_ff;
   logic [7:0]          bright_ff;
   logic [TIME_W-1:0]   interval_ff;
   logic [TIME_W-1:0]   period_ff;
   logic [TIME_W-1:0]   on_time_ff;
   logic [7:0]          step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         show_en_ff  <= 1'b1;
         mode_ff     <= MODE_FIXED;
         color_ff    <= '0;
         bright_ff   <= 8'd255;
         interval_ff <= '0;
         period_ff   <= '0;
         on_time_ff  <= '0;
         step_ff     <= 8'd1;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_SHOW_ENABLE:     show_en_ff  <= csr_wdata[0];
            CSR_MODE:            mode_ff     <= mode_type'(csr_wdata[1:0]);
            CSR_COLOR_RGB:       color_ff    <= csr_wdata[23:0];
            CSR_BRIGHTNESS:      bright_ff   <= csr_wdata[7:0];
            CSR_UPDATE_INTERVAL: interval_ff <= csr_wdata[TIME_W-1:0];
            CSR_BLINK_PERIOD:    period_ff   <= csr_wdata[TIME_W-1:0];
            CSR_BLINK_ON_TIME:   on_time_ff  <= csr_wdata[TIME_W-1:0];
            CSR_STEP_SIZE:       step_ff     <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // credit counter: slots reserved in the result FIFO
   // ------------------------------------------------------------------
   logic [PTR_W:0] used_ff, used_in;
   logic [PTR_W:0] wr_ptr_ff, rd_ptr_ff;
   logic           req_acc, rsp_acc, drop;

   assign req_tready = (used_ff < (PTR_W+1)'(FIFO_DEPTH));
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_tvalid = (wr_ptr_ff != rd_ptr_ff);
   assign rsp_acc    = rsp_tvalid && rsp_tready;

   assign used_in = used_ff + (PTR_W+1)'(req_acc) - (PTR_W+1)'(rsp_acc)
                    - (PTR_W+1)'(drop);

   always_ff @(posedge clock) begin
      if (reset) used_ff <= '0;
      else       used_ff <= used_in;
   end

   // ------------------------------------------------------------------
   // stage 0: input register
   // ------------------------------------------------------------------
   logic                s0_valid_ff;
   logic [TIME_W-1:0]   now_ff;

   always_ff @(posedge clock) begin
      if (reset) s0_valid_ff <= 1'b0;
      else       s0_valid_ff <= req_acc;
   end

   always_ff @(posedge clock) begin
      if (req_acc) now_ff <= req_tdata;
   end

   // ------------------------------------------------------------------
   // effect state
   // ------------------------------------------------------------------
   logic [TIME_W-1:0]             last_upd_ff, last_upd_in;
   logic [TIME_W-1:0]             blink_start_ff, blink_start_in;
   logic                          blink_lit_ff, blink_lit_in;
   logic                          rising_ff, rising_in;
   logic [7:0]                    wheel_pos_ff, wheel_pos_in;
   logic [2:0][COMP_W-1:0]        wc_ff, wc_in;
   logic                          reload_pend_ff, reload_pend_in;
   logic                          out_pend_ff, out_pend_in;

   // combinational helpers
   logic [2:0][7:0]               base;
   logic [2:0][COMP_W-1:0]        src;
   logic [2:0][COMP_W-1:0]        br_next;
   logic [2:0][COMP_W-1:0]        whl;
   logic [2:0][COMP_W-1:0]        col;
   logic [2:0][7:0]               clip;
   logic [2:0]                    rise_ok, fall_ok;
   logic [COMP_W-1:0]             step11;
   logic [COMP_W:0]               step12, rise_lim;
   logic [TIME_W-1:0]             gap, elapsed;
   logic                          fire, blink_toggle, breathe_turn, out_pend_next, emit;
   logic [7:0]                    wpos_c, wseg;
   logic [9:0]                    wseg_x3;

   assign base[0] = color_ff[23:16];
   assign base[1] = color_ff[15:8];
   assign base[2] = color_ff[7:0];

   assign step11   = {{(COMP_W-8){step_ff[7]}}, step_ff};
   assign step12   = {step11[COMP_W-1], step11};
   assign rise_lim = (COMP_W+1)'(255) - step12;     // 255 - step, signed

   assign gap     = now_ff - last_upd_ff;
   assign elapsed = now_ff - blink_start_ff;
   assign fire    = s0_valid_ff && show_en_ff && ((interval_ff == '0) || (gap >= interval_ff));

   // blink: lit phase ends after on time, dark phase after the period
   assign blink_toggle = blink_lit_ff ? (elapsed >= on_time_ff) : (elapsed >= period_ff);

   // breathe: step every component, turn when all reached the end stop
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         src[i]     = reload_pend_ff ? {{(COMP_W-8){1'b0}}, base[i]} : wc_ff[i];
         br_next[i] = rising_ff ? (src[i] + step11) : (src[i] - step11);
         rise_ok[i] = ($signed({br_next[i][COMP_W-1], br_next[i]}) >= $signed(rise_lim))
                      || ($signed(br_next[i]) >= $signed(COMP_W'(255)));
         fall_ok[i] = ($signed(step12) >= $signed({br_next[i][COMP_W-1], br_next[i]}))
                      || ($signed(br_next[i]) <= $signed(COMP_W'(1)));
      end
   end

   assign breathe_turn = rising_ff ? (&rise_ok) : (&fall_ok);

   // color wheel: three segments of 85, 85 and 86 positions
   assign wpos_c  = FULL_LEVEL - wheel_pos_ff;
   assign wseg    = (wpos_c < WHEEL_SEG1) ? wpos_c
                  : (wpos_c < WHEEL_SEG2) ? (wpos_c - WHEEL_SEG1)
                  :                         (wpos_c - WHEEL_SEG2);
   assign wseg_x3 = {2'b00, wseg} + {1'b0, wseg, 1'b0};

   always_comb begin
      whl = '0;
      if (wpos_c < WHEEL_SEG1) begin
         whl[0] = COMP_W'(wseg_x3);
         whl[1] = COMP_W'(10'd255 - wseg_x3);
      end else if (wpos_c < WHEEL_SEG2) begin
         whl[0] = COMP_W'(10'd255 - wseg_x3);
         whl[2] = COMP_W'(wseg_x3);
      end else begin
         whl[1] = COMP_W'(wseg_x3);
         whl[2] = COMP_W'(10'd255 - wseg_x3);
      end
   end

   // state update for the word in stage 0
   always_comb begin
      last_upd_in    = last_upd_ff;
      blink_start_in = blink_start_ff;
      blink_lit_in   = blink_lit_ff;
      rising_in      = rising_ff;
      wheel_pos_in   = wheel_pos_ff;
      wc_in          = wc_ff;
      out_pend_next  = out_pend_ff;
      col            = '0;

      if (fire) begin
         last_upd_in = now_ff;
         case (mode_ff)
            MODE_FIXED: begin
               for (int i = 0; i < 3; i++) col[i] = {{(COMP_W-8){1'b0}}, base[i]};
            end
            MODE_BLINK: begin
               wc_in = src;
               if (blink_toggle) begin
                  blink_lit_in  = !blink_lit_ff;
                  out_pend_next = 1'b1;
                  if (!blink_lit_ff) blink_start_in = now_ff;
               end
               // dark phase shows black
               if (blink_lit_ff ^ blink_toggle) col = src;
            end
            MODE_BREATHE: begin
               wc_in         = br_next;
               out_pend_next = 1'b1;
               if (breathe_turn) rising_in = !rising_ff;
               col = br_next;
            end
            MODE_WHEEL: begin
               wc_in         = whl;
               wheel_pos_in  = wheel_pos_ff + step_ff;
               out_pend_next = 1'b1;
               col = whl;
            end
            default: ;
         endcase
      end

      emit = fire && out_pend_next;

      out_pend_in    = emit ? 1'b0 : out_pend_ff;
      reload_pend_in = emit ? 1'b0 : reload_pend_ff;
      if (csr_wr_en) begin
         out_pend_in    = 1'b1;
         reload_pend_in = 1'b1;
      end

      // clip to 0..255
      for (int i = 0; i < 3; i++) begin
         if (col[i][COMP_W-1])       clip[i] = 8'd0;
         else if (|col[i][COMP_W-2:8]) clip[i] = FULL_LEVEL;
         else                        clip[i] = col[i][7:0];
      end
   end

   assign drop = s0_valid_ff && !emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_upd_ff    <= '0;
         blink_start_ff <= '0;
         blink_lit_ff   <= 1'b0;
         rising_ff      <= 1'b0;
         wheel_pos_ff   <= '0;
         wc_ff          <= '0;
         reload_pend_ff <= 1'b1;
         out_pend_ff    <= 1'b1;
      end else begin
         last_upd_ff    <= last_upd_in;
         blink_start_ff <= blink_start_in;
         blink_lit_ff   <= blink_lit_in;
         rising_ff      <= rising_in;
         wheel_pos_ff   <= wheel_pos_in;
         wc_ff          <= wc_in;
         reload_pend_ff <= reload_pend_in;
         out_pend_ff    <= out_pend_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 1: clipped levels; stage 2: brightness products
   // ------------------------------------------------------------------
   logic                s1_valid_ff, s2_valid_ff;
   logic [2:0][7:0]     lvl_s1_ff;
   logic [2:0][15:0]    prod_s2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= emit;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) lvl_s1_ff <= clip;
      if (s1_valid_ff) begin
         for (int i = 0; i < 3; i++) prod_s2_ff[i] <= lvl_s1_ff[i] * bright_ff;
      end
   end

   // round(p / 255) as floor((2p + 255) / 510) by reciprocal multiply
   logic [2:0][16:0]    div_num;
   logic [2:0][34:0]    div_prod;
   logic [3*LEVEL_W-1:0] result;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         div_num[i]  = {prod_s2_ff[i], 1'b0} + 17'd255;
         div_prod[i] = div_num[i] * DIV510_MULT;
         result[i*LEVEL_W +: LEVEL_W] = div_prod[i][DIV510_SHIFT +: LEVEL_W];
      end
   end

   // ------------------------------------------------------------------
   // result FIFO
   // ------------------------------------------------------------------
   logic [3*LEVEL_W-1:0] fifo_mem [FIFO_DEPTH];

   always_ff @(posedge clock) begin
      if (s2_valid_ff) fifo_mem[wr_ptr_ff[PTR_W-1:0]] <= result;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         if (s2_valid_ff) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (rsp_acc)     rd_ptr_ff <= rd_ptr_ff + 1'b1;
      end
   end

   assign rsp_tdata = fifo_mem[rd_ptr_ff[PTR_W-1:0]];

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
`ifndef SYNTHESIS
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= (PTR_W+1)'(FIFO_DEPTH))
      else $error("credit counter above FIFO depth");

   a_fifo_within_credit: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) <= used_ff)
      else $error("FIFO holds more words than reserved");

   a_reload_has_output: assert property (@(posedge clock) disable iff (reset)
      reload_pend_ff |-> out_pend_ff)
      else $error("reload pending without output pending");

   a_write_forces_output: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> (reload_pend_ff && out_pend_ff))
      else $error("register write did not set pending flags");
`endif

endmodule : rgb_status_led_effects

`default_nettype wire

FILE: tb/tb_rgb_status_led_effects.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_status_led_effects
// Self-checking bench for the RGB status LED effect generator. A scoreboard
// class keeps its own copy of the registers and effect state. It predicts the
// duty levels for every accepted time stamp and checks each response word in
// order. A short directed pass covers all four modes and the corner cases.
// Randomized phases follow, most with fresh settings for a random subset of
// the registers, and with random idling on both streams.
// ----------------------------------------------------------------------------

module tb_rgb_status_led_effects
   import rgbled_pkg::*;
();

   // -------------------------------------------------------------------------
   // Scoreboard: register shadow, effect predictor, queue of expected levels
   // -------------------------------------------------------------------------
   class led_scoreboard;
      bit                       show_en;
      mode_type                 mode;
      logic [23:0]              base_rgb;
      logic [7:0]               bright;
      logic [31:0]              interval;
      logic [31:0]              period;
      logic [31:0]              on_time;
      logic signed [7:0]        step;

      logic [31:0]              last_upd;
      logic [31:0]              blink_t0;
      bit                       lit;
      bit                       rising;
      bit                       reload;
      bit                       out_due;
      logic [7:0]               wheel_pos;
      logic signed [COMP_W-1:0] work_col [3];

      logic [23:0]              levels_q [$];
      int                       mismatches;

      function new();
         show_en    = 1'b1;
         mode       = MODE_FIXED;
         base_rgb   = '0;
         bright     = 8'hFF;
         interval   = '0;
         period     = '0;
         on_time    = '0;
         step       = 8'sd1;
         last_upd   = '0;
         blink_t0   = '0;
         lit        = 1'b0;
         rising     = 1'b0;
         wheel_pos  = '0;
         work_col   = '{default: '0};
         reload     = 1'b1;
         out_due    = 1'b1;
         mismatches = 0;
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10) $display("%s", msg);
      endfunction

      function int waiting();
         return levels_q.size();
      endfunction

      // any write, even of the same value, forces a reload and one output
      function void write_reg(csr_index_type idx, logic [31:0] v);
         case (idx)
            CSR_SHOW_ENABLE:     show_en  = v[0];
            CSR_MODE:            mode     = mode_type'(v[1:0]);
            CSR_COLOR_RGB:       base_rgb = v[23:0];
            CSR_BRIGHTNESS:      bright   = v[7:0];
            CSR_UPDATE_INTERVAL: interval = v;
            CSR_BLINK_PERIOD:    period   = v;
            CSR_BLINK_ON_TIME:   on_time  = v;
            CSR_STEP_SIZE:       step     = v[7:0];
            default: ;
         endcase
         reload  = 1'b1;
         out_due = 1'b1;
      endfunction

      // clip to 0..255, then round(c * brightness / 255)
      function logic [7:0] scale(int c);
         int unsigned v;
         v = (c < 0) ? 0 : (c > 255) ? 255 : c;
         return 8'((v * bright * 2 + 255) / 510);
      endfunction

      function void breathe_step();
         int s;
         int c;
         bit all_turn;
         s        = step;
         all_turn = 1'b1;
         for (int i = 0; i < 3; i++) begin
            c           = work_col[i];
            c           = rising ? c + s : c - s;
            work_col[i] = c[COMP_W-1:0];   // wraps in 11 bits
            c           = work_col[i];
            if (rising) begin
               if (!(c >= 255 - s || c >= 255)) all_turn = 1'b0;
            end else begin
               if (!(s >= c || c <= 1)) all_turn = 1'b0;
            end
         end
         if (all_turn) rising = !rising;
      endfunction

      function void wheel_step();
         int c;
         int r;
         int g;
         int b;
         c = 255 - wheel_pos;
         if (c < WHEEL_SEG1) begin
            r = 3 * c;
            g = 255 - 3 * c;
            b = 0;
         end else if (c < WHEEL_SEG2) begin
            c = c - WHEEL_SEG1;
            r = 255 - 3 * c;
            g = 0;
            b = 3 * c;
         end else begin
            c = c - WHEEL_SEG2;
            r = 0;
            g = 3 * c;
            b = 255 - 3 * c;
         end
         work_col[0] = r[COMP_W-1:0];
         work_col[1] = g[COMP_W-1:0];
         work_col[2] = b[COMP_W-1:0];
         wheel_pos   = wheel_pos + step;
      endfunction

      // one accepted time stamp: advance the effect, queue a result if due
      function void note_tick(logic [31:0] now);
         int          col [3];
         logic [31:0] since;
         bit          toggle;
         if (!show_en) return;
         since = now - last_upd;
         if (interval != 0 && since < interval) return;
         last_upd = now;
         col = '{0, 0, 0};
         if (mode == MODE_FIXED) begin
            col[0] = base_rgb[23:16];
            col[1] = base_rgb[15:8];
            col[2] = base_rgb[7:0];
         end else begin
            if (reload) begin
               work_col[0] = {3'b000, base_rgb[23:16]};
               work_col[1] = {3'b000, base_rgb[15:8]};
               work_col[2] = {3'b000, base_rgb[7:0]};
            end
            case (mode)
               MODE_BLINK: begin
                  since  = now - blink_t0;
                  toggle = 1'b0;
                  if (lit) begin
                     toggle = (since >= on_time);
                  end else if (since >= period) begin
                     blink_t0 = now;
                     toggle   = 1'b1;
                  end
                  if (toggle) begin
                     lit     = !lit;
                     out_due = 1'b1;
                  end
               end
               MODE_BREATHE: begin
                  breathe_step();
                  out_due = 1'b1;
               end
               default: begin
                  wheel_step();
                  out_due = 1'b1;
               end
            endcase
            // dark blink phase stays black
            if (mode != MODE_BLINK || lit)
               for (int i = 0; i < 3; i++) col[i] = work_col[i];
         end
         if (!out_due) return;
         levels_q.push_back({scale(col[2]), scale(col[1]), scale(col[0])});
         out_due = 1'b0;
         reload  = 1'b0;
      endfunction

      function void check_levels(logic [23:0] got);
         logic [23:0] want;
         if (levels_q.size() == 0) begin
            flag($sformatf("unexpected level word r=%0d g=%0d b=%0d",
                           got[7:0], got[15:8], got[23:16]));
            return;
         end
         want = levels_q.pop_front();
         if (got[7:0] !== want[7:0] || got[15:8] !== want[15:8] ||
             got[23:16] !== want[23:16])
            flag($sformatf("level mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                           want[7:0], want[15:8], want[23:16],
                           got[7:0], got[15:8], got[23:16]));
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT signals
   // -------------------------------------------------------------------------
   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [TIME_W-1:0]     req_tdata;     // [31:0] now_time
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [3*LEVEL_W-1:0]  rsp_tdata;     // [7:0] red, [15:8] green, [23:16] blue
   logic                  csr_wr_en;
   logic [2:0]            csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // idle_mode: 0 none, 1 sender idles 55%, 2 receiver stalls 55%, 3 both 33%
   int            idle_mode;
   int            hold_left;     // long receiver hold-off, counted down per cycle
   int            counted;       // random words sent while show is on and the interval is at most 100
   led_scoreboard sb = new();

   rgb_status_led_effects DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 4 ns clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #2_000_000;
      $display("tb_rgb_status_led_effects: done, errors");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Response side: ready changes on the falling edge, words checked on rising
   // -------------------------------------------------------------------------
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (idle_mode == 2) begin
            rsp_tready <= ($urandom_range(99) >= 55);
         end else if (idle_mode == 3) begin
            rsp_tready <= ($urandom_range(99) >= 33);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_levels(rsp_tdata);
   end

   // -------------------------------------------------------------------------
   // Request side helpers
   // -------------------------------------------------------------------------
   function automatic int sender_gap();
      int gap = 0;
      int pct;
      if (idle_mode != 1 && idle_mode != 3) return 0;
      pct = (idle_mode == 1) ? 55 : 33;
      while (gap < 24 && $urandom_range(99) < pct) gap++;
      return gap;
   endfunction

   // Offer one time stamp word; returns on the falling edge after acceptance
   // with tvalid still high, so back-to-back words need no idle gap.
   task automatic send_tick(input logic [31:0] stamp);
      int gap;
      gap = sender_gap();
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= stamp;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_tick(stamp);
      @(negedge clock);
   endtask

   // Stop offering, wait for every expected word, then let words that
   // give no result clear the pipeline before touching registers.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.waiting() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   // Register write; only called while the block is idle.
   task automatic write_csr(input csr_index_type idx, input logic [31:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      sb.write_reg(idx, value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      logic [31:0]   time_base;
      logic [31:0]   stamp;
      logic [31:0]   value;
      int            n_items;
      int            phase;
      int            pick;
      csr_index_type idx;

      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_wr_en  = 1'b0;
      csr_index  = CSR_SHOW_ENABLE;
      csr_wdata  = '0;
      idle_mode  = 0;
      hold_left  = 0;
      counted    = 0;
      reset      = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed: fixed mode ---
      send_tick(32'h0000_0000);     // output pending from reset: black
      send_tick(32'hFFFF_FFFF);     // nothing pending: no word
      settle();
      write_csr(CSR_COLOR_RGB, 32'h00FF_8001);
      send_tick(32'd5);
      settle();
      write_csr(CSR_BRIGHTNESS, 32'd0);
      send_tick(32'd6);             // zero brightness
      settle();
      write_csr(CSR_BRIGHTNESS, 32'd127);
      write_csr(CSR_SHOW_ENABLE, 32'd0);
      send_tick(32'd7);             // show disabled: tick ignored
      settle();
      write_csr(CSR_SHOW_ENABLE, 32'd1);

      // --- directed: blink ---
      write_csr(CSR_MODE, MODE_BLINK);
      write_csr(CSR_BLINK_PERIOD, 32'd10);
      write_csr(CSR_BLINK_ON_TIME, 32'd4);
      send_tick(32'd20);            // dark -> lit
      send_tick(32'd22);            // still lit, nothing
      send_tick(32'd24);            // lit -> dark, black
      send_tick(32'd26);
      settle();
      write_csr(CSR_BLINK_ON_TIME, 32'd6);
      send_tick(32'd27);            // no toggle, pending: dark phase black
      send_tick(32'd30);            // dark -> lit
      settle();
      write_csr(CSR_BLINK_PERIOD, 32'd10);   // same value still forces output
      send_tick(32'd31);            // no toggle, pending: lit color
      settle();
      write_csr(CSR_UPDATE_INTERVAL, 32'd5);
      send_tick(32'd33);            // too soon after last update
      send_tick(32'd36);
      settle();
      write_csr(CSR_UPDATE_INTERVAL, 32'd0);

      // --- directed: breathe, clipping and turn-around ---
      write_csr(CSR_MODE, MODE_BREATHE);
      write_csr(CSR_STEP_SIZE, 32'd100);
      write_csr(CSR_COLOR_RGB, 32'h00FF_1000);
      for (int i = 0; i < 4; i++) send_tick(32'd40 + i);
      settle();
      write_csr(CSR_STEP_SIZE, 32'h0000_0080);   // most negative step
      send_tick(32'd44);
      send_tick(32'd45);
      settle();

      // --- directed: color wheel, all three segments ---
      write_csr(CSR_MODE, MODE_WHEEL);
      write_csr(CSR_STEP_SIZE, 32'h0000_0055);
      for (int i = 0; i < 3; i++) send_tick(32'd50 + i);
      settle();
      write_csr(CSR_STEP_SIZE, 32'h0000_00FF);   // step backwards
      send_tick(32'd53);
      send_tick(32'd54);
      settle();

      // --- random phases ---
      // Time base wraps early on; one word in ten is a random stamp.
      time_base = 32'hFFFF_FF00;
      phase     = 0;
      while (counted < 1150) begin
         idle_mode = phase % 4;
         if (phase == 2) begin
            // every tick gives a word, receiver holds off: FIFO fills and
            // req_tready has to drop
            write_csr(CSR_SHOW_ENABLE, 32'd1);
            write_csr(CSR_MODE, MODE_WHEEL);
            write_csr(CSR_UPDATE_INTERVAL, 32'd0);
            idle_mode = 0;
            hold_left = 64;
            n_items   = 48;
         end else begin
            for (int i = 0; i < 8; i++) begin
               idx  = csr_index_type'(i);
               pick = $urandom_range(15);
               case (idx)
                  CSR_SHOW_ENABLE:
                     value = (pick == 0) ? ($urandom & ~32'h1) : ($urandom | 32'h1);
                  CSR_MODE:
                     value = $urandom;
                  CSR_COLOR_RGB:
                     value = (pick == 0) ? 32'h0 : (pick == 1) ? 32'h00FF_FFFF : $urandom;
                  CSR_BRIGHTNESS:
                     value = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFF : $urandom;
                  CSR_UPDATE_INTERVAL:
                     value = (pick == 0) ? $urandom :
                             (pick <= 6) ? $urandom_range(20, 1) : 32'h0;
                  CSR_BLINK_PERIOD:
                     value = (pick == 0) ? 32'hFFFF_FFFF : $urandom_range(60);
                  CSR_BLINK_ON_TIME:
                     value = (pick == 0) ? $urandom : $urandom_range(70);
                  default:
                     value = (pick == 0) ? 32'h7F : (pick == 1) ? 32'h80 :
                             (pick == 2) ? 32'h0  : (pick <= 4) ? $urandom :
                             $urandom_range(40, 1);
               endcase
               if ($urandom_range(1) == 1) write_csr(idx, value);
            end
            n_items = $urandom_range(48, 16);
         end

         for (int k = 0; k < n_items; k++) begin
            if ($urandom_range(9) == 0) begin
               stamp     = $urandom;
               time_base = stamp;
            end else begin
               time_base = time_base + $urandom_range(12);
               stamp     = time_base;
            end
            send_tick(stamp);
            if (sb.show_en && sb.interval <= 100) counted++;
         end
         // sender pauses until everything expected has come back
         settle();
         phase++;
      end

      if (sb.waiting() != 0)
         sb.flag($sformatf("%0d expected level words never arrived", sb.waiting()));
      if (sb.mismatches == 0) begin
         $display("tb_rgb_status_led_effects: done, clean");
      end else begin
         $display("tb_rgb_status_led_effects: done, errors");
      end
      $finish;
   end

endmodule

FILE: files.f
design/rgbled_pkg.sv
design/rgb_status_led_effects.sv
tb/tb_rgb_status_led_effects.sv
